FILE: rtl/core/slab_free_list_allocator_macros.svh
// Assertion macros shared by the checker files of the slab allocator.
// Depends on nothing; the including scope must provide clock and reset.
`ifndef SLAB_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SLAB_FREE_LIST_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFLA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFLA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/sfla_pkg.sv
// Package for the slab free list allocator: sizes, codes, control types and
// the microprogram ROM. Depends on nothing.
`timescale 1ns / 1ps

package sfla_pkg;

   // Geometry
   localparam int OBJS_PER_SLAB = 128;
   localparam int MAX_SLABS     = 16;
   localparam int WORD_BYTES    = 8;

   localparam int SLOT_W     = $clog2(OBJS_PER_SLAB);
   localparam int SLAB_W     = $clog2(MAX_SLABS);
   localparam int COUNT_W    = $clog2(MAX_SLABS + 1);
   localparam int LINK_W     = $clog2(OBJS_PER_SLAB + 1);
   localparam int ADDR_W     = SLAB_W + SLOT_W;
   localparam int RAM_DEPTH  = MAX_SLABS * OBJS_PER_SLAB;
   localparam int WORD_SHIFT = $clog2(WORD_BYTES);

   // Field widths
   localparam int OBJ_W    = 13;
   localparam int STRIDE_W = OBJ_W + 1;
   localparam int PROD_W   = SLOT_W + STRIDE_W;
   localparam int OFF_W    = 20;
   localparam int STATUS_W = 2;

   // Head value that marks an empty free list
   localparam logic [LINK_W-1:0] LINK_EMPTY = '1;

   localparam logic [OBJ_W-1:0] OBJ_BYTES_RESET = OBJ_W'(8);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_BAD_FREE  = 2'd2
   } status_type;

   // Datapath operation selected by a control word
   typedef enum logic [2:0] {
      ACT_WAIT   = 3'd0,
      ACT_SELECT = 3'd1,
      ACT_TAKE   = 3'd2,
      ACT_POP    = 3'd3,
      ACT_OFFSET = 3'd4,
      ACT_FREE   = 3'd5,
      ACT_EMIT   = 3'd6
   } act_type;

   // Sequencing of the step counter
   typedef enum logic [2:0] {
      JMP_NEXT = 3'd0,   // step + 1
      JMP_GOTO = 3'd1,   // target
      JMP_REQ  = 3'd2,   // hold until a word is taken; free -> target
      JMP_EXH  = 3'd3,   // exhausted -> target, else step + 1
      JMP_OUT  = 3'd4    // hold while result register is full, then target
   } jump_type;

   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_WAIT   = 3'd0;
   localparam step_type STEP_SELECT = 3'd1;
   localparam step_type STEP_TAKE   = 3'd2;
   localparam step_type STEP_POP    = 3'd3;
   localparam step_type STEP_OFFSET = 3'd4;
   localparam step_type STEP_FREE   = 3'd5;
   localparam step_type STEP_EMIT   = 3'd6;

   typedef struct packed {
      act_type  act;
      jump_type jmp;
      step_type target;
   } ucode_type;

   // Control passed from sequencer to datapath
   typedef struct packed {
      act_type act;
   } ctrl_type;

   // Condition flags passed from datapath to sequencer
   typedef struct packed {
      logic req_fire;
      logic req_func;
      logic exhausted;
      logic out_busy;
   } flags_type;

   // Microprogram
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      unique case (step)
         STEP_WAIT:   w = '{act: ACT_WAIT,   jmp: JMP_REQ,  target: STEP_FREE};
         STEP_SELECT: w = '{act: ACT_SELECT, jmp: JMP_EXH,  target: STEP_EMIT};
         STEP_TAKE:   w = '{act: ACT_TAKE,   jmp: JMP_NEXT, target: STEP_WAIT};
         STEP_POP:    w = '{act: ACT_POP,    jmp: JMP_NEXT, target: STEP_WAIT};
         STEP_OFFSET: w = '{act: ACT_OFFSET, jmp: JMP_GOTO, target: STEP_EMIT};
         STEP_FREE:   w = '{act: ACT_FREE,   jmp: JMP_GOTO, target: STEP_EMIT};
         STEP_EMIT:   w = '{act: ACT_EMIT,   jmp: JMP_OUT,  target: STEP_WAIT};
         default:     w = '{act: ACT_WAIT,   jmp: JMP_GOTO, target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/sfla_req_if.sv
// Request channel interface: valid/ready handshake plus request word.
// Depends on sfla_pkg.
`timescale 1ns / 1ps

interface sfla_req_if import sfla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [SLAB_W-1:0] rel_slab;
   logic [SLOT_W-1:0] free_slot;

   modport source (output valid, func, rel_slab, free_slot, input ready);
   modport sink   (input valid, func, rel_slab, free_slot, output ready);
endinterface

FILE: rtl/core/sfla_rsp_if.sv
// Response channel interface: valid/ready handshake plus result word.
// Depends on sfla_pkg.
`timescale 1ns / 1ps

interface sfla_rsp_if import sfla_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLAB_W-1:0]   slab_index;
   logic [SLOT_W-1:0]   slot_index;
   logic [OFF_W-1:0]    byte_offset;
   logic [COUNT_W-1:0]  slabs_in_use;

   modport source (output valid, status, slab_index, slot_index, byte_offset, slabs_in_use,
                   input ready);
   modport sink   (input valid, status, slab_index, slot_index, byte_offset, slabs_in_use,
                   output ready);
endinterface

FILE: rtl/core/slab_free_list_allocator.sv
// Slab free list allocator. Takes one request word at a time; an allocate
// runs the select, take, pop and offset steps of the control microprogram,
// with the registered read of the 2048 x 8 slot link RAM between take and
// pop, then the emit step that loads the result register; an exhausted
// allocate goes from select straight to emit, and a free runs the free step,
// then emit. A full output register holds the sequencer in its emit step.
// The link RAM needs no clearing pass: entries are read only after a free has
// written them. A new request is taken as soon as the sequencer is back in its
// wait step, even while a result still sits in the output register.
// object_bytes must be written only while the block is idle; the block itself
// does not enforce this.
// Depends on sfla_pkg, sfla_req_if, sfla_rsp_if, sfla_seq and sfla_datapath.
`timescale 1ns / 1ps

module slab_free_list_allocator import sfla_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   sfla_req_if.sink         req_chan,
   sfla_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [OBJ_W-1:0] csr_wr_data
);

   ctrl_type  ctrl;
   flags_type flags;

   // Microprogram sequencer
   sfla_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // Datapath and link memory
   sfla_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctrl        (ctrl),
      .flags       (flags)
   );

endmodule

FILE: rtl/core/sfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module sfla_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sfla_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on sfla_pkg.
`timescale 1ns / 1ps

module sfla_seq import sfla_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   step_type  step_ff;
   step_type  step_in;
   ucode_type uword;

   assign uword    = ucode_rom(step_ff);
   assign ctrl.act = uword.act;

   // Next step
   always_comb begin
      step_in = step_ff;
      unique case (uword.jmp)
         JMP_NEXT: step_in = step_ff + 1'b1;
         JMP_GOTO: step_in = uword.target;
         JMP_REQ: begin
            if (flags.req_fire) begin
               step_in = flags.req_func ? uword.target : step_ff + 1'b1;
            end
         end
         JMP_EXH:  step_in = flags.exhausted ? uword.target : step_ff + 1'b1;
         JMP_OUT: begin
            if (!flags.out_busy) begin
               step_in = uword.target;
            end
         end
         default:  step_in = STEP_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: rtl/core/sfla_datapath.sv
// Allocator datapath: per-slab list heads and fresh counters, slot link RAM,
// slab selection, offset multiply and result register. Depends on sfla_pkg,
// sfla_req_if, sfla_rsp_if and sfla_ram.
`timescale 1ns / 1ps

module sfla_datapath import sfla_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   sfla_req_if.sink         req_chan,
   sfla_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [OBJ_W-1:0] csr_wr_data,
   input  ctrl_type         ctrl,
   output flags_type        flags
);

   // Control state
   logic [LINK_W-1:0]  head_ff  [MAX_SLABS];
   logic [LINK_W-1:0]  head_in  [MAX_SLABS];
   logic [LINK_W-1:0]  fresh_ff [MAX_SLABS];
   logic [LINK_W-1:0]  fresh_in [MAX_SLABS];
   logic [SLAB_W-1:0]  recent_ff, recent_in;
   logic               recent_valid_ff, recent_valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [OBJ_W-1:0]   object_bytes_ff, object_bytes_in;
   logic               pop_ff, pop_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-request working registers
   logic               func_ff, func_in;
   logic [SLAB_W-1:0]  slab_ff, slab_in;
   logic [SLOT_W-1:0]  fslot_ff, fslot_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   status_type         status_ff, status_in;

   // Result register
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLAB_W-1:0]   rsp_slab_ff, rsp_slab_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [OFF_W-1:0]    rsp_off_ff, rsp_off_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // Combinational
   logic [MAX_SLABS-1:0] room;
   logic [MAX_SLABS-1:0] in_use;
   logic                 scan_found;
   logic [SLAB_W-1:0]    scan_idx;
   logic                 recent_hit;
   logic                 can_new;
   logic                 exhausted;
   logic [LINK_W-1:0]    head_sel;
   logic [LINK_W-1:0]    fresh_sel;
   logic [STRIDE_W-1:0]  round_sum;
   logic [STRIDE_W-1:0]  stride;
   logic [PROD_W-1:0]    product;
   logic                 bad_free;
   logic                 req_fire;
   logic                 out_busy;
   logic                 out_load;
   logic                 ok_alloc;

   // Link RAM ports
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [LINK_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [LINK_W-1:0] ram_rd_data;

   sfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (RAM_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Handshakes
   assign req_chan.ready = (ctrl.act == ACT_WAIT);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_busy       = rsp_valid_ff && !rsp_chan.ready;
   assign out_load       = (ctrl.act == ACT_EMIT) && !out_busy;

   // Room per slab and newest-first scan over slabs in use
   always_comb begin
      scan_found = 1'b0;
      scan_idx   = '0;
      for (int i = 0; i < MAX_SLABS; i++) begin
         room[i]   = (head_ff[i] != LINK_EMPTY) || (fresh_ff[i] < LINK_W'(OBJS_PER_SLAB));
         in_use[i] = COUNT_W'(i) < count_ff;
         if (room[i] && in_use[i]) begin
            scan_found = 1'b1;
            scan_idx   = SLAB_W'(i);
         end
      end
   end

   assign recent_hit = recent_valid_ff && (COUNT_W'(recent_ff) < count_ff) && room[recent_ff];
   assign can_new    = count_ff < COUNT_W'(MAX_SLABS);
   assign exhausted  = !recent_hit && !scan_found && !can_new;

   // Head and fresh counter selected at the working slab
   assign head_sel  = head_ff[slab_ff];
   assign fresh_sel = fresh_ff[slab_ff];

   // Slot stride: size rounded up to a word, plus one link word
   assign round_sum = STRIDE_W'(object_bytes_ff) + STRIDE_W'(WORD_BYTES - 1);
   assign stride    = {round_sum[STRIDE_W-1:WORD_SHIFT], WORD_SHIFT'(0)}
                      + STRIDE_W'(WORD_BYTES);
   assign product   = PROD_W'(slot_ff) * PROD_W'(stride);

   assign bad_free = ({1'b0, slab_ff} >= count_ff)
                     || (LINK_W'(fslot_ff) >= LINK_W'(OBJS_PER_SLAB));
   assign ok_alloc = !func_ff && (status_ff == ST_OK);

   assign flags.req_fire  = req_fire;
   assign flags.req_func  = req_chan.func;
   assign flags.exhausted = exhausted;
   assign flags.out_busy  = out_busy;

   // Next-state logic driven by the current control word
   always_comb begin
      head_in         = head_ff;
      fresh_in        = fresh_ff;
      recent_in       = recent_ff;
      recent_valid_in = recent_valid_ff;
      count_in        = count_ff;
      object_bytes_in = csr_wr_en ? csr_wr_data : object_bytes_ff;
      pop_in          = pop_ff;
      func_in         = func_ff;
      slab_in         = slab_ff;
      fslot_in        = fslot_ff;
      slot_in         = slot_ff;
      off_in          = off_ff;
      status_in       = status_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_slab_in     = rsp_slab_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_off_in      = rsp_off_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = {slab_ff, fslot_ff};
      ram_wr_data     = head_sel;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = {slab_ff, head_sel[SLOT_W-1:0]};

      unique case (ctrl.act)
         // Take the request word; a free names its slab up front
         ACT_WAIT: begin
            if (req_fire) begin
               func_in  = req_chan.func;
               slab_in  = req_chan.rel_slab;
               fslot_in = req_chan.free_slot;
            end
         end
         // Pick the slab: recent, else newest with room, else a new one, else exhausted
         ACT_SELECT: begin
            status_in = ST_OK;
            if (recent_hit) begin
               slab_in = recent_ff;
            end else if (scan_found) begin
               slab_in         = scan_idx;
               recent_in       = scan_idx;
               recent_valid_in = 1'b1;
            end else if (can_new) begin
               slab_in  = count_ff[SLAB_W-1:0];
               count_in = count_ff + 1'b1;
            end else begin
               status_in = ST_EXHAUSTED;
            end
         end
         // Pop a freed slot (link read in flight) or issue a fresh one
         ACT_TAKE: begin
            if (head_sel != LINK_EMPTY) begin
               slot_in   = head_sel[SLOT_W-1:0];
               pop_in    = 1'b1;
               ram_rd_en = 1'b1;
            end else begin
               slot_in           = fresh_sel[SLOT_W-1:0];
               fresh_in[slab_ff] = fresh_sel + 1'b1;
               pop_in            = 1'b0;
            end
         end
         ACT_POP: begin
            if (pop_ff) begin
               head_in[slab_ff] = ram_rd_data;
            end
         end
         ACT_OFFSET: begin
            off_in = product[OFF_W-1:0];
         end
         // Push the freed slot onto its slab's list, or flag a bad free
         ACT_FREE: begin
            if (bad_free) begin
               status_in = ST_BAD_FREE;
            end else begin
               status_in        = ST_OK;
               ram_wr_en        = 1'b1;
               head_in[slab_ff] = LINK_W'(fslot_ff);
            end
         end
         ACT_EMIT: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slab_in   = ok_alloc ? slab_ff : '0;
               rsp_slot_in   = ok_alloc ? slot_ff : '0;
               rsp_off_in    = ok_alloc ? off_ff : '0;
               rsp_count_in  = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLABS; i++) begin
            head_ff[i]  <= LINK_EMPTY;
            fresh_ff[i] <= '0;
         end
         recent_ff       <= '0;
         recent_valid_ff <= 1'b0;
         count_ff        <= '0;
         object_bytes_ff <= OBJ_BYTES_RESET;
         pop_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         head_ff         <= head_in;
         fresh_ff        <= fresh_in;
         recent_ff       <= recent_in;
         recent_valid_ff <= recent_valid_in;
         count_ff        <= count_in;
         object_bytes_ff <= object_bytes_in;
         pop_ff          <= pop_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      slab_ff       <= slab_in;
      fslot_ff      <= fslot_in;
      slot_ff       <= slot_in;
      off_ff        <= off_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slab_ff   <= rsp_slab_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.slab_index   = rsp_slab_ff;
   assign rsp_chan.slot_index   = rsp_slot_ff;
   assign rsp_chan.byte_offset  = rsp_off_ff;
   assign rsp_chan.slabs_in_use = rsp_count_ff;

endmodule

FILE: rtl/core/sfla_checker.sv
// Port-level checker for the slab allocator, bound to the top level.
// Depends on sfla_pkg and slab_free_list_allocator_macros.svh.
`timescale 1ns / 1ps
`include "slab_free_list_allocator_macros.svh"

module sfla_checker import sfla_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLAB_W-1:0]   rsp_slab_index,
   input logic [SLOT_W-1:0]   rsp_slot_index,
   input logic [OFF_W-1:0]    rsp_byte_offset,
   input logic [COUNT_W-1:0]  rsp_slabs_in_use
);

   // A result word is held until taken
   `SFLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // One request in flight: ready drops right after a word is taken
   `SFLA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // Status codes are ok, exhausted or bad free only
   `SFLA_ASSERT_SAME(a_status_code, rsp_valid, rsp_status <= STATUS_W'(ST_BAD_FREE))

   // Failed requests carry no slot
   `SFLA_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp_status != STATUS_W'(ST_OK)),
      (rsp_slab_index == '0) && (rsp_slot_index == '0) && (rsp_byte_offset == '0))

   // Slab count never exceeds the pool
   `SFLA_ASSERT_SAME(a_count_range, rsp_valid, rsp_slabs_in_use <= COUNT_W'(MAX_SLABS))

endmodule

bind slab_free_list_allocator sfla_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_slab_index   (rsp_chan.slab_index),
   .rsp_slot_index   (rsp_chan.slot_index),
   .rsp_byte_offset  (rsp_chan.byte_offset),
   .rsp_slabs_in_use (rsp_chan.slabs_in_use)
);
